FILE: rtl/pixel_tone_and_duotone_filter_macros.svh
// assertion macros shared by the pixel tone and duotone filter rtl
// no dependencies; the NO_ASSERTIONS switch leaves every use empty
`ifndef PIXEL_TONE_AND_DUOTONE_FILTER_MACROS_SVH
`define PIXEL_TONE_AND_DUOTONE_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define PTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/ptdf_pkg.sv
// shared types, register indexes and mode codes of the tone and duotone filter
// no dependencies
package ptdf_pkg;

    // register indexes of the write port
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd1;
    localparam logic [2:0] REG_CONTRAST   = 3'd2;
    localparam logic [2:0] REG_THRESHOLD  = 3'd3;
    localparam logic [2:0] REG_DARK       = 3'd4;
    localparam logic [2:0] REG_BRIGHT     = 3'd5;
    localparam logic [2:0] REG_GRAD_EN    = 3'd6;
    localparam logic [2:0] REG_ROWS       = 3'd7;

    // filter modes
    localparam logic [2:0] MODE_PASS       = 3'd0;
    localparam logic [2:0] MODE_BRIGHTNESS = 3'd1;
    localparam logic [2:0] MODE_CONTRAST   = 3'd2;
    localparam logic [2:0] MODE_INVERT     = 3'd3;
    localparam logic [2:0] MODE_THRESHOLD  = 3'd4;
    localparam logic [2:0] MODE_DUOTONE    = 3'd5;

    // reset values of the registers
    localparam logic [2:0]  RST_MODE       = MODE_PASS;
    localparam logic [6:0]  RST_BRIGHTNESS = 7'd50;
    localparam logic [6:0]  RST_CONTRAST   = 7'd50;
    localparam logic [7:0]  RST_THRESHOLD  = 8'd127;
    localparam logic [47:0] RST_DARK       = 48'h0;
    localparam logic [47:0] RST_BRIGHT     = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0]  RST_GRAD_EN    = 2'd0;
    localparam logic [11:0] RST_ROWS       = 12'd480;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_DATA_W = 48;

    typedef struct packed {
        logic [2:0]  mode;
        logic [6:0]  brightness;
        logic [6:0]  contrast;
        logic [7:0]  threshold;
        logic [47:0] dark;
        logic [47:0] bright;
        logic [1:0]  grad_en;
        logic [11:0] rows;
    } t_cfg;

    // one classified pixel: channel 0 blue, 1 green, 2 red
    typedef struct packed {
        logic [2:0][7:0]  pix;
        logic [2:0][14:0] cnum;
        logic             bin;
        logic [10:0]      row;
        logic             row_end;
        logic             frame_end;
    } t_item;

endpackage

FILE: rtl/ptdf_front.sv
// front part: takes pixels, forms gray level, binary class and contrast products
// depends on ptdf_pkg; keeps the row counter
module ptdf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptdf_pkg::t_cfg    i_cfg,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [23:0]       i_s_axis_tdata,   // blue, green, red
    input  logic              i_s_axis_tlast,   // row end
    input  logic              i_s_axis_tuser,   // frame end
    input  logic              i_push_ready,
    output logic              o_push,
    output ptdf_pkg::t_item   o_item
);

    localparam logic [21:0] WEIGHT_B   = 22'd1868;
    localparam logic [21:0] WEIGHT_G   = 22'd9617;
    localparam logic [21:0] WEIGHT_R   = 22'd4899;
    localparam logic [21:0] GRAY_ROUND = 22'd8192;

    logic [10:0] r_row;
    logic [10:0] n_row;
    logic [21:0] gray_sum;
    logic [7:0]  gray;
    logic        accept;

    assign o_s_axis_tready = i_push_ready;
    assign accept          = i_s_axis_tvalid && i_push_ready;
    assign o_push          = accept;

    // gray level
    always_comb begin
        gray_sum = {14'd0, i_s_axis_tdata[7:0]} * WEIGHT_B
                 + {14'd0, i_s_axis_tdata[15:8]} * WEIGHT_G
                 + {14'd0, i_s_axis_tdata[23:16]} * WEIGHT_R
                 + GRAY_ROUND;
        gray     = gray_sum[21:14];
    end

    // item fields
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_item.pix[k]  = i_s_axis_tdata[8*k +: 8];
            o_item.cnum[k] = {7'd0, i_s_axis_tdata[8*k +: 8]} * {8'd0, i_cfg.contrast};
        end
        o_item.bin       = gray > i_cfg.threshold;
        o_item.row       = r_row;
        o_item.row_end   = i_s_axis_tlast;
        o_item.frame_end = i_s_axis_tuser;
    end

    // row counter: frame end clears, row end advances
    always_comb begin
        n_row = r_row;
        if (accept) begin
            if (i_s_axis_tuser) begin
                n_row = 11'd0;
            end else if (i_s_axis_tlast) begin
                n_row = r_row + 11'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 11'd0;
        end else begin
            r_row <= n_row;
        end
    end

endmodule

FILE: rtl/ptdf_queue.sv
// short queue of classified pixels between front and back
// depends on ptdf_pkg for the item type
module ptdf_queue #(
    parameter int DEPTH = ptdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ptdf_pkg::t_item i_item,
    output logic            o_push_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output ptdf_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ptdf_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_valid      = r_count != '0;
    assign o_item       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: rtl/ptdf_back.sv
// back part: applies the selected filter and owns the per-row gradient engine
// depends on ptdf_pkg and the assertion macro header
`include "pixel_tone_and_duotone_filter_macros.svh"

module ptdf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptdf_pkg::t_cfg  i_cfg,
    input  logic            i_cfg_we,
    input  logic            i_q_valid,
    input  ptdf_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [23:0]     o_m_axis_tdata,   // blue, green, red
    output logic            o_m_axis_tlast,   // row end
    output logic            o_m_axis_tuser    // frame end
);

    localparam logic [1:0] ENG_IDLE = 2'd0;
    localparam logic [1:0] ENG_MUL  = 2'd1;
    localparam logic [1:0] ENG_DIV  = 2'd2;
    localparam logic [2:0] LAST_IDX = 3'd5;
    localparam logic [12:0] RECIP_50 = 13'd5243;

    // engine state
    logic [1:0]  r_eng_state, n_eng_state;
    logic [2:0]  r_eng_idx, n_eng_idx;
    logic [2:0]  r_eng_bit, n_eng_bit;
    logic [19:0] r_eng_rem, n_eng_rem;
    logic [7:0]  r_eng_q, n_eng_q;
    logic [10:0] r_eng_row, n_eng_row;
    logic        r_cache_valid, n_cache_valid;
    logic [10:0] r_cache_row, n_cache_row;
    logic [23:0] r_dark_grad, n_dark_grad;
    logic [23:0] r_bright_grad, n_bright_grad;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [23:0] r_out_pix, n_out_pix;
    logic        r_out_last, n_out_last;
    logic        r_out_user, n_out_user;

    // engine datapath
    logic        sel_bright;
    logic [1:0]  eng_ch;
    logic [23:0] col_start, col_end;
    logic [7:0]  c1, c2;
    logic [11:0] den;
    logic        few_rows;
    logic [11:0] erow;
    logic [19:0] eng_num;
    logic [19:0] den_sh;
    logic        ge;
    logic [7:0]  q_new;
    logic [7:0]  eng_byte;
    logic        eng_done_val;
    logic        eng_finish;
    logic        eng_busy;
    logic        eng_start;

    // item side
    logic        need_grad;
    logic        hit;
    logic        can_load;
    logic [23:0] res_pix;

    function automatic logic [7:0] bright_chan(input logic [7:0] c, input logic [6:0] lvl);
        logic [8:0] t;
        logic [8:0] d;
        t = {1'b0, c} + {2'b0, lvl};
        d = t - 9'd50;
        if (t < 9'd50) begin
            return 8'd0;
        end else if (d > 9'd255) begin
            return 8'hFF;
        end
        return d[7:0];
    endfunction

    // num / 50 by reciprocal (exact below 2^15), round half to even, saturate
    function automatic logic [7:0] contrast_chan(input logic [14:0] num);
        logic [27:0] prod;
        logic [9:0]  q;
        logic [14:0] qm;
        logic [14:0] r;
        logic        up;
        logic [10:0] q2;
        prod = {13'd0, num} * {15'd0, RECIP_50};
        q    = prod[27:18];
        qm   = {5'd0, q} * 15'd50;
        r    = num - qm;
        up   = (r > 15'd25) || ((r == 15'd25) && q[0]);
        q2   = {1'b0, q} + {10'd0, up};
        if (q2 > 11'd255) begin
            return 8'hFF;
        end
        return q2[7:0];
    endfunction

    assign eng_busy = r_eng_state != ENG_IDLE;
    assign can_load = !r_out_valid || i_m_axis_tready;
    assign hit      = r_cache_valid && (r_cache_row == i_q_item.row);

    // does the head pixel take a gradient color
    always_comb begin
        need_grad = (i_cfg.mode == ptdf_pkg::MODE_DUOTONE)
                 && ((!i_q_item.bin && i_cfg.grad_en[0]) || (i_q_item.bin && i_cfg.grad_en[1]));
    end

    assign o_q_pop   = i_q_valid && can_load && !eng_busy && (!need_grad || hit);
    assign eng_start = i_q_valid && !eng_busy && need_grad && !hit;

    // gradient engine operands
    always_comb begin
        sel_bright = r_eng_idx >= 3'd3;
        eng_ch     = sel_bright ? 2'(r_eng_idx - 3'd3) : r_eng_idx[1:0];
        col_start  = sel_bright ? i_cfg.bright[23:0] : i_cfg.dark[23:0];
        col_end    = sel_bright ? i_cfg.bright[47:24] : i_cfg.dark[47:24];
        c1         = col_start[{eng_ch, 3'b000} +: 8];
        c2         = col_end[{eng_ch, 3'b000} +: 8];
        den        = i_cfg.rows - 12'd1;
        few_rows   = i_cfg.rows < 12'd2;
        erow       = ({1'b0, r_eng_row} > den) ? den : {1'b0, r_eng_row};
        eng_num    = ({12'd0, c1} * {8'd0, den - erow}) + ({12'd0, c2} * {8'd0, erow});
        den_sh     = {8'd0, den} << r_eng_bit;
        ge         = r_eng_rem >= den_sh;
        q_new      = {r_eng_q[6:0], ge};
    end

    // gradient engine sequencing, per channel: one multiply step, then eight quotient bits (none when rows < 2)
    always_comb begin
        n_eng_state   = r_eng_state;
        n_eng_idx     = r_eng_idx;
        n_eng_bit     = r_eng_bit;
        n_eng_rem     = r_eng_rem;
        n_eng_q       = r_eng_q;
        n_eng_row     = r_eng_row;
        n_cache_valid = r_cache_valid;
        n_cache_row   = r_cache_row;
        n_dark_grad   = r_dark_grad;
        n_bright_grad = r_bright_grad;
        eng_byte      = q_new;
        eng_done_val  = 1'b0;
        eng_finish    = 1'b0;
        case (r_eng_state)
            ENG_IDLE: begin
                if (eng_start) begin
                    n_eng_state = ENG_MUL;
                    n_eng_idx   = 3'd0;
                    n_eng_row   = i_q_item.row;
                end
            end
            ENG_MUL: begin
                if (few_rows) begin
                    eng_byte     = c1;
                    eng_done_val = 1'b1;
                end else begin
                    n_eng_rem   = eng_num;
                    n_eng_bit   = 3'd7;
                    n_eng_q     = 8'd0;
                    n_eng_state = ENG_DIV;
                end
            end
            ENG_DIV: begin
                n_eng_q = q_new;
                if (ge) begin
                    n_eng_rem = r_eng_rem - den_sh;
                end
                if (r_eng_bit == 3'd0) begin
                    eng_done_val = 1'b1;
                end else begin
                    n_eng_bit = r_eng_bit - 3'd1;
                end
            end
            default: begin
                n_eng_state = ENG_IDLE;
            end
        endcase
        // store a finished channel and move on
        if (eng_done_val) begin
            if (sel_bright) begin
                n_bright_grad[{eng_ch, 3'b000} +: 8] = eng_byte;
            end else begin
                n_dark_grad[{eng_ch, 3'b000} +: 8] = eng_byte;
            end
            if (r_eng_idx == LAST_IDX) begin
                eng_finish    = 1'b1;
                n_eng_state   = ENG_IDLE;
                n_cache_valid = 1'b1;
                n_cache_row   = r_eng_row;
            end else begin
                n_eng_idx   = r_eng_idx + 3'd1;
                n_eng_state = ENG_MUL;
            end
        end
        // any register write makes the cached colors stale
        if (i_cfg_we) begin
            n_cache_valid = 1'b0;
        end
    end

    // per-channel result of the head pixel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (i_cfg.mode)
                ptdf_pkg::MODE_BRIGHTNESS: begin
                    res_pix[8*k +: 8] = bright_chan(i_q_item.pix[k], i_cfg.brightness);
                end
                ptdf_pkg::MODE_CONTRAST: begin
                    res_pix[8*k +: 8] = contrast_chan(i_q_item.cnum[k]);
                end
                ptdf_pkg::MODE_INVERT: begin
                    res_pix[8*k +: 8] = ~i_q_item.pix[k];
                end
                ptdf_pkg::MODE_THRESHOLD: begin
                    res_pix[8*k +: 8] = {8{i_q_item.bin}};
                end
                ptdf_pkg::MODE_DUOTONE: begin
                    if (need_grad) begin
                        res_pix[8*k +: 8] = i_q_item.bin ? r_bright_grad[8*k +: 8]
                                                         : r_dark_grad[8*k +: 8];
                    end else begin
                        res_pix[8*k +: 8] = {8{i_q_item.bin}};
                    end
                end
                default: begin
                    res_pix[8*k +: 8] = i_q_item.pix[k];
                end
            endcase
        end
    end

    // output register load
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_pix   = r_out_pix;
        n_out_last  = r_out_last;
        n_out_user  = r_out_user;
        if (can_load) begin
            n_out_valid = o_q_pop;
        end
        if (o_q_pop) begin
            n_out_pix  = res_pix;
            n_out_last = i_q_item.row_end;
            n_out_user = i_q_item.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng_state   <= ENG_IDLE;
            r_cache_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_eng_state   <= n_eng_state;
            r_cache_valid <= n_cache_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eng_idx     <= n_eng_idx;
        r_eng_bit     <= n_eng_bit;
        r_eng_rem     <= n_eng_rem;
        r_eng_q       <= n_eng_q;
        r_eng_row     <= n_eng_row;
        r_cache_row   <= n_cache_row;
        r_dark_grad   <= n_dark_grad;
        r_bright_grad <= n_bright_grad;
        r_out_pix     <= n_out_pix;
        r_out_last    <= n_out_last;
        r_out_user    <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pix;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_user;

    // checks
    `PTD_ASSERT_IMP(a_pop_engine_idle, i_clk, i_rst_n, o_q_pop, r_eng_state == ENG_IDLE, "pixel request taken while gradient engine busy")
    `PTD_ASSERT_IMP(a_grad_from_cache, i_clk, i_rst_n, o_q_pop && need_grad, hit, "gradient pixel taken without matching row colors")
    `PTD_ASSERT_NEXT(a_finish_fills_cache, i_clk, i_rst_n, eng_finish && !i_cfg_we, r_cache_valid && (r_cache_row == $past(r_eng_row)), "gradient run did not fill the row cache")

endmodule

FILE: rtl/pixel_tone_and_duotone_filter.sv
// channel | dir | handshake                         | payload
// s_axis  | in  | i_s_axis_tvalid / o_s_axis_tready | tdata bgr, tlast row end, tuser frame end
// m_axis  | out | o_m_axis_tvalid / i_m_axis_tready | tdata bgr, tlast row end, tuser frame end
// cfg     | in  | i_cfg_we                          | i_cfg_index, i_cfg_data
//
// one pixel per clock while the output is ready, unless a duotone gradient pixel finds no cached
// colors for its row (first such pixel of a row or after any register write): it then waits for
// a start step plus six channels of one multiply and eight divide steps (the multiply alone
// when rows < 2), while the QUEUE_DEPTH-entry queue keeps the input open until it fills; input
// passes through the queue memory and the output register; synchronous active-low reset clears
// the row counter, queue, engine and output valid and loads the register defaults
module pixel_tone_and_duotone_filter #(
    parameter int QUEUE_DEPTH = ptdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // in_blue, in_green, in_red
    input  logic        i_s_axis_tlast,   // row_end
    input  logic        i_s_axis_tuser,   // frame_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // out_blue, out_green, out_red
    output logic        o_m_axis_tlast,   // out_row_end
    output logic        o_m_axis_tuser,   // out_frame_end
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [ptdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ptdf_pkg::t_cfg  r_cfg, n_cfg;
    ptdf_pkg::t_item push_item;
    ptdf_pkg::t_item head_item;
    logic            push;
    logic            push_ready;
    logic            head_valid;
    logic            pop;

    // register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                ptdf_pkg::REG_MODE:       n_cfg.mode       = i_cfg_data[2:0];
                ptdf_pkg::REG_BRIGHTNESS: n_cfg.brightness = i_cfg_data[6:0];
                ptdf_pkg::REG_CONTRAST:   n_cfg.contrast   = i_cfg_data[6:0];
                ptdf_pkg::REG_THRESHOLD:  n_cfg.threshold  = i_cfg_data[7:0];
                ptdf_pkg::REG_DARK:       n_cfg.dark       = i_cfg_data[47:0];
                ptdf_pkg::REG_BRIGHT:     n_cfg.bright     = i_cfg_data[47:0];
                ptdf_pkg::REG_GRAD_EN:    n_cfg.grad_en    = i_cfg_data[1:0];
                ptdf_pkg::REG_ROWS:       n_cfg.rows       = i_cfg_data[11:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= ptdf_pkg::RST_MODE;
            r_cfg.brightness <= ptdf_pkg::RST_BRIGHTNESS;
            r_cfg.contrast   <= ptdf_pkg::RST_CONTRAST;
            r_cfg.threshold  <= ptdf_pkg::RST_THRESHOLD;
            r_cfg.dark       <= ptdf_pkg::RST_DARK;
            r_cfg.bright     <= ptdf_pkg::RST_BRIGHT;
            r_cfg.grad_en    <= ptdf_pkg::RST_GRAD_EN;
            r_cfg.rows       <= ptdf_pkg::RST_ROWS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front: classify pixels
    ptdf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_push_ready    (push_ready),
        .o_push          (push),
        .o_item          (push_item)
    );

    // queue between front and back
    ptdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_valid      (head_valid),
        .o_item       (head_item)
    );

    // back: filter and gradient engine
    ptdf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cfg_we        (i_cfg_we),
        .i_q_valid       (head_valid),
        .i_q_item        (head_item),
        .o_q_pop         (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
